// ----- hw/rtl/navigation_safety_supervisor_assert.svh -----
// assertion macros for the navigation safety supervisor
`ifndef NAVIGATION_SAFETY_SUPERVISOR_ASSERT_SVH
`define NAVIGATION_SAFETY_SUPERVISOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define NSS_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("nss assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define NSS_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("nss assertion failed");

`endif

// ----- hw/rtl/nss_pkg.sv -----
// types, codes and constants of the navigation safety supervisor
`default_nettype none

package nss_pkg;

  localparam int TIME_WIDTH = 32;
  localparam logic [31:0] TIME_MASK = 32'((64'd1 << TIME_WIDTH) - 64'd1);

  localparam int NUM_CNT = 12;

  localparam int C_TRANS    = 0;
  localparam int C_WDOG     = 1;
  localparam int C_ACCEPT   = 2;
  localparam int C_INVALID  = 3;
  localparam int C_OVERFLOW = 9;
  localparam int C_MANUAL   = 10;
  localparam int C_NUMFAULT = 11;

  localparam logic [3:0] SEL_LIMIT = 4'(NUM_CNT);

  localparam logic [1:0] CFG_HOST_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_UNAV_GRACE   = 2'd1;
  localparam logic [1:0] CFG_OVF_LIMIT    = 2'd2;

  localparam logic [2:0] NAV_LANDMARK = 3'd1;
  localparam logic [2:0] NAV_DEAD_RECK = 3'd2;
  localparam logic [2:0] NAV_DEGRADED = 3'd3;
  localparam logic [2:0] NAV_UNAVAIL  = 3'd4;

  localparam logic [2:0] REASON_INVALID   = 3'd1;
  localparam logic [2:0] REASON_OVERSIZED = 3'd6;

  typedef enum logic [2:0] {
    MODE_STARTUP  = 3'd0,
    MODE_SELFTEST = 3'd1,
    MODE_READY    = 3'd2,
    MODE_RUNNING  = 3'd3,
    MODE_DEGRADED = 3'd4,
    MODE_SAFESTOP = 3'd5,
    MODE_FAULT    = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    KIND_TICK     = 4'd0,
    KIND_RESTART  = 4'd1,
    KIND_ST_START = 4'd2,
    KIND_ST_DONE  = 4'd3,
    KIND_HANDSHAKE = 4'd4,
    KIND_ACCEPTED = 4'd5,
    KIND_REJECTED = 4'd6,
    KIND_OVERFLOW = 4'd7,
    KIND_STOP_REQ = 4'd8,
    KIND_NUM_FAULT = 4'd9,
    KIND_READ_CNT = 4'd10
  } kind_t;

  typedef struct packed {
    logic [15:0] host_timeout;
    logic [15:0] unavailable_grace;
    logic [7:0]  overflow_stop_limit;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_ms;
    logic [2:0]  nav_mode;
    logic        estimator_ok;
    logic        control_ok;
    logic        self_test_pass;
    logic [2:0]  reject_reason;
    logic [3:0]  counter_select;
  } item_t;

  typedef struct packed {
    mode_t                     mode;
    logic                      host_contact;
    logic [31:0]               last_input_time;
    logic [31:0]               outage_start;
    logic                      outage_timing;
    logic [NUM_CNT-1:0][31:0]  cnt;
  } state_t;

  // packed so that state_out lands in the lowest bits
  typedef struct packed {
    logic [31:0] counter_value;
    logic        request_accepted;
    logic        neutral_hold;
    logic        brake_demand;
    logic        drive_permit;
    mode_t       state_out;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nss_eval.sv -----
// single-pass evaluation of one item against the supervisor state
`default_nettype none

module nss_eval (
  input  nss_pkg::state_t  st,
  input  nss_pkg::item_t   item,
  input  nss_pkg::cfg_t    cfg,
  output nss_pkg::state_t  st_next,
  output nss_pkg::result_t res
);

  always_comb begin
    logic [2:0]                 nav;
    logic                       aided;
    logic                       dr;
    logic                       unav;
    logic                       live;
    logic [31:0]                now;
    logic [31:0]                el_host;
    logic [31:0]                el_outage;
    logic [31:0]                ovf_cnt;
    logic [nss_pkg::NUM_CNT-1:0] inc;
    nss_pkg::mode_t             m;

    st_next = st;
    res     = '0;
    inc     = '0;
    nav     = (item.nav_mode > nss_pkg::NAV_UNAVAIL) ? nss_pkg::NAV_UNAVAIL : item.nav_mode;
    aided   = (nav <= nss_pkg::NAV_LANDMARK);
    dr      = (nav == nss_pkg::NAV_DEAD_RECK) || (nav == nss_pkg::NAV_DEGRADED);
    unav    = (nav == nss_pkg::NAV_UNAVAIL);
    now     = item.now_ms & nss_pkg::TIME_MASK;
    el_host   = (now - st.last_input_time) & nss_pkg::TIME_MASK;
    el_outage = (now - st.outage_start) & nss_pkg::TIME_MASK;
    ovf_cnt   = st.cnt[nss_pkg::C_OVERFLOW] + 32'd1;
    live = (st.mode == nss_pkg::MODE_READY) || (st.mode == nss_pkg::MODE_RUNNING) ||
           (st.mode == nss_pkg::MODE_DEGRADED);
    m = st.mode;

    case (item.kind)
      nss_pkg::KIND_TICK: begin
        if (live && st.host_contact && (el_host > {16'd0, cfg.host_timeout})) begin
          inc[nss_pkg::C_WDOG] = 1'b1;
          m = nss_pkg::MODE_SAFESTOP;
        end
        if ((m == nss_pkg::MODE_RUNNING || m == nss_pkg::MODE_DEGRADED) &&
            !item.estimator_ok) begin
          inc[nss_pkg::C_NUMFAULT] = 1'b1;
          m = nss_pkg::MODE_FAULT;
        end
        if (m == nss_pkg::MODE_READY && st.host_contact && item.estimator_ok &&
            item.control_ok) begin
          if (aided) begin
            m = nss_pkg::MODE_RUNNING;
          end else if (dr) begin
            m = nss_pkg::MODE_DEGRADED;
          end
        end else if (m == nss_pkg::MODE_RUNNING) begin
          if (dr) begin
            st_next.outage_timing = 1'b0;
            m = nss_pkg::MODE_DEGRADED;
          end else if (unav) begin
            st_next.outage_timing = 1'b1;
            st_next.outage_start  = now;
            m = nss_pkg::MODE_DEGRADED;
          end else begin
            st_next.outage_timing = 1'b0;
          end
        end else if (m == nss_pkg::MODE_DEGRADED) begin
          if (aided) begin
            st_next.outage_timing = 1'b0;
            m = nss_pkg::MODE_RUNNING;
          end else if (dr) begin
            st_next.outage_timing = 1'b0;
          end else if (!st.outage_timing) begin
            st_next.outage_timing = 1'b1;
            st_next.outage_start  = now;
          end else if (el_outage >= {16'd0, cfg.unavailable_grace}) begin
            m = nss_pkg::MODE_SAFESTOP;
          end
        end
        if ((m == nss_pkg::MODE_RUNNING || m == nss_pkg::MODE_DEGRADED) &&
            item.estimator_ok && !unav && item.control_ok) begin
          res.drive_permit = 1'b1;
        end else if (m == nss_pkg::MODE_SAFESTOP || m == nss_pkg::MODE_FAULT) begin
          res.brake_demand = 1'b1;
        end else begin
          res.neutral_hold = 1'b1;
        end
      end
      nss_pkg::KIND_RESTART: begin
        m = nss_pkg::MODE_STARTUP;
        st_next.host_contact    = 1'b0;
        st_next.outage_timing   = 1'b0;
        st_next.last_input_time = now;
        st_next.outage_start    = now;
      end
      nss_pkg::KIND_ST_START: begin
        if (st.mode == nss_pkg::MODE_STARTUP) begin
          m = nss_pkg::MODE_SELFTEST;
          res.request_accepted = 1'b1;
        end
      end
      nss_pkg::KIND_ST_DONE: begin
        if (st.mode == nss_pkg::MODE_SELFTEST) begin
          m = item.self_test_pass ? nss_pkg::MODE_READY : nss_pkg::MODE_FAULT;
          res.request_accepted = 1'b1;
        end
      end
      nss_pkg::KIND_HANDSHAKE, nss_pkg::KIND_ACCEPTED: begin
        if (live) begin
          st_next.host_contact    = 1'b1;
          st_next.last_input_time = now;
          inc[nss_pkg::C_ACCEPT]  = (item.kind == nss_pkg::KIND_ACCEPTED);
        end
      end
      nss_pkg::KIND_REJECTED: begin
        for (int i = 0; i < 6; i++) begin
          inc[nss_pkg::C_INVALID + i] = (item.reject_reason == nss_pkg::REASON_INVALID + 3'(i));
        end
      end
      nss_pkg::KIND_OVERFLOW: begin
        inc[nss_pkg::C_OVERFLOW] = 1'b1;
        if (ovf_cnt >= {24'd0, cfg.overflow_stop_limit} && st.mode != nss_pkg::MODE_FAULT) begin
          m = nss_pkg::MODE_SAFESTOP;
        end
      end
      nss_pkg::KIND_STOP_REQ: begin
        inc[nss_pkg::C_MANUAL] = 1'b1;
        if (st.mode != nss_pkg::MODE_FAULT) begin
          m = nss_pkg::MODE_SAFESTOP;
        end
      end
      nss_pkg::KIND_NUM_FAULT: begin
        inc[nss_pkg::C_NUMFAULT] = 1'b1;
        m = nss_pkg::MODE_FAULT;
      end
      nss_pkg::KIND_READ_CNT: begin
        if (item.counter_select < nss_pkg::SEL_LIMIT) begin
          res.counter_value = st.cnt[item.counter_select];
        end
      end
      default: begin
      end
    endcase

    // at most one mode change per item, so one transition count
    inc[nss_pkg::C_TRANS] = (m != st.mode);

    for (int i = 0; i < nss_pkg::NUM_CNT; i++) begin
      st_next.cnt[i] = st.cnt[i] + {31'd0, inc[i]};
    end
    if (item.kind == nss_pkg::KIND_RESTART) begin
      st_next.cnt = '0;
    end

    st_next.mode  = m;
    res.state_out = m;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/navigation_safety_supervisor.sv -----
// navigation safety supervisor: mode, watchdog, outage timer and event counters
// a result is valid in the cycle after its item is accepted
// throughput: one item per cycle unless stalled; one pass of logic into the result register
// the result register frees in the same cycle it is taken, so stalls cost only stalled cycles
// reset (rst, synchronous): mode startup, timers and counters zero, registers at defaults
`default_nettype none
`include "navigation_safety_supervisor_assert.svh"

module navigation_safety_supervisor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // now_ms[31:0], nav_mode[34:32], estimator_ok[35], control_ok[36],
  // self_test_pass[37], reject_reason[40:38], counter_select[44:41], zero pad
  input  wire logic [47:0] s_tdata,
  // kind[3:0]
  input  wire logic [3:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // state_out[2:0], drive_permit[3], brake_demand[4], neutral_hold[5],
  // request_accepted[6], counter_value[38:7], zero pad
  output logic [39:0]      m_tdata
);

  nss_pkg::cfg_t    cfg;
  nss_pkg::state_t  st;
  nss_pkg::state_t  st_next;
  nss_pkg::item_t   item;
  nss_pkg::result_t res;
  nss_pkg::result_t res_q;
  logic             s_accept;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  assign item.kind           = nss_pkg::kind_t'(s_tuser);
  assign item.now_ms         = s_tdata[31:0];
  assign item.nav_mode       = s_tdata[34:32];
  assign item.estimator_ok   = s_tdata[35];
  assign item.control_ok     = s_tdata[36];
  assign item.self_test_pass = s_tdata[37];
  assign item.reject_reason  = s_tdata[40:38];
  assign item.counter_select = s_tdata[44:41];

  nss_eval u_eval (
    .st      (st),
    .item    (item),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  // zero writes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.host_timeout        <= 16'd500;
      cfg.unavailable_grace   <= 16'd250;
      cfg.overflow_stop_limit <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        nss_pkg::CFG_HOST_TIMEOUT: begin
          if (cfg_wdata != 16'd0) cfg.host_timeout <= cfg_wdata;
        end
        nss_pkg::CFG_UNAV_GRACE: begin
          if (cfg_wdata != 16'd0) cfg.unavailable_grace <= cfg_wdata;
        end
        nss_pkg::CFG_OVF_LIMIT: begin
          if (cfg_wdata[7:0] != 8'd0) cfg.overflow_stop_limit <= cfg_wdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode            <= nss_pkg::MODE_STARTUP;
      st.host_contact    <= 1'b0;
      st.last_input_time <= 32'd0;
      st.outage_start    <= 32'd0;
      st.outage_timing   <= 1'b0;
      st.cnt             <= '0;
    end else if (s_accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      res_q <= res;
    end
  end

  assign m_tdata = {1'b0, res_q};

  `NSS_ASSERT_NEXT(a_accept_gives_result, s_accept, m_tvalid)
  `NSS_ASSERT_NEXT(a_restart_clears, s_accept && s_tuser == nss_pkg::KIND_RESTART,
                   st.mode == nss_pkg::MODE_STARTUP && st.cnt == '0)
  `NSS_ASSERT_NOW(a_flags_exclusive, m_tvalid,
                  $countones({res_q.drive_permit, res_q.brake_demand, res_q.neutral_hold}) <= 1)
  `NSS_ASSERT_NOW(a_force_in_stop, m_tvalid && res_q.brake_demand,
                  res_q.state_out == nss_pkg::MODE_SAFESTOP ||
                  res_q.state_out == nss_pkg::MODE_FAULT)

endmodule

`default_nettype wire

// ----- tb/navigation_safety_supervisor_tb.sv -----
// self-checking testbench for the navigation safety supervisor: event stream against a shadow model
module navigation_safety_supervisor_tb;
  import nss_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 320;
  localparam int HOLD_CYCLES  = 90;
  localparam int IDLE_PCT     = 37;

  localparam logic [3:0] KIND_SPARE_FIRST = 4'd11;
  localparam logic [3:0] KIND_SPARE_LAST  = 4'd15;
  localparam logic [2:0] NAV_GNSS         = 3'd0;
  localparam logic [2:0] NAV_SPARE_LAST   = 3'd7;
  localparam logic [2:0] REASON_NONE      = 3'd0;
  localparam logic [2:0] REASON_SPARE     = 3'd7;
  localparam logic [3:0] SEL_SPARE_LAST   = 4'd15;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] now;
    logic [2:0]  nav;
    logic        est_ok;
    logic        ctl_ok;
    logic        pass;
    logic [2:0]  reason;
    logic [3:0]  sel;
  } event_t;

  class safety_shadow;
    mode_t       mode;
    bit          contact;
    logic [31:0] last_in;
    logic [31:0] outage_at;
    bit          outage_on;
    logic [31:0] cnt [NUM_CNT];
    logic [15:0] host_to;
    logic [15:0] grace;
    logic [7:0]  ovf_limit;
    result_t     pending [$];
    int          errors;
    int          checked;
    bit [6:0]    modes_seen;

    function new();
      host_to = 16'd500;
      grace = 16'd250;
      ovf_limit = 8'd1;
      errors = 0;
      checked = 0;
      modes_seen = '0;
      wipe(32'd0);
    endfunction

    function void wipe(logic [31:0] now);
      for (int i = 0; i < NUM_CNT; i++) cnt[i] = '0;
      mode = MODE_STARTUP;
      last_in = now;
      outage_at = now;
      contact = 1'b0;
      outage_on = 1'b0;
    endfunction

    function void move_to(mode_t next);
      if (next != mode) begin
        mode = next;
        cnt[C_TRANS] += 1;
      end
    endfunction

    function void num_fault();
      cnt[C_NUMFAULT] += 1;
      move_to(MODE_FAULT);
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        CFG_HOST_TIMEOUT: if (v != 16'd0) host_to = v;
        CFG_UNAV_GRACE:   if (v != 16'd0) grace = v;
        CFG_OVF_LIMIT:    if (v[7:0] != 8'd0) ovf_limit = v[7:0];
        default: ;
      endcase
    endfunction

    function void take_event(event_t e);
      logic [31:0] now;
      logic [2:0]  nav;
      bit          aided;
      bit          dr;
      bit          unav;
      bit          live;
      result_t     r;
      now = e.now & TIME_MASK;
      nav = (e.nav > NAV_UNAVAIL) ? NAV_UNAVAIL : e.nav;
      aided = nav <= NAV_LANDMARK;
      dr = (nav == NAV_DEAD_RECK) || (nav == NAV_DEGRADED);
      unav = nav == NAV_UNAVAIL;
      live = (mode == MODE_READY) || (mode == MODE_RUNNING) || (mode == MODE_DEGRADED);
      r = '0;
      case (e.kind)
        KIND_TICK: begin
          if (live && contact && ((now - last_in) & TIME_MASK) > 32'(host_to)) begin
            cnt[C_WDOG] += 1;
            move_to(MODE_SAFESTOP);
          end
          if ((mode == MODE_RUNNING || mode == MODE_DEGRADED) && !e.est_ok) num_fault();
          if (mode == MODE_READY && contact && e.est_ok && e.ctl_ok) begin
            if (aided) move_to(MODE_RUNNING);
            else if (dr) move_to(MODE_DEGRADED);
          end else if (mode == MODE_RUNNING) begin
            if (dr) begin
              outage_on = 1'b0;
              move_to(MODE_DEGRADED);
            end else if (unav) begin
              outage_on = 1'b1;
              outage_at = now;
              move_to(MODE_DEGRADED);
            end else begin
              outage_on = 1'b0;
            end
          end else if (mode == MODE_DEGRADED) begin
            if (aided) begin
              outage_on = 1'b0;
              move_to(MODE_RUNNING);
            end else if (dr) begin
              outage_on = 1'b0;
            end else if (!outage_on) begin
              outage_on = 1'b1;
              outage_at = now;
            end else if (((now - outage_at) & TIME_MASK) >= 32'(grace)) begin
              move_to(MODE_SAFESTOP);
            end
          end
          if ((mode == MODE_RUNNING || mode == MODE_DEGRADED) && e.est_ok && !unav && e.ctl_ok)
            r.drive_permit = 1'b1;
          else if (mode == MODE_SAFESTOP || mode == MODE_FAULT)
            r.brake_demand = 1'b1;
          else
            r.neutral_hold = 1'b1;
        end
        KIND_RESTART: wipe(now);
        KIND_ST_START: begin
          if (mode == MODE_STARTUP) begin
            move_to(MODE_SELFTEST);
            r.request_accepted = 1'b1;
          end
        end
        KIND_ST_DONE: begin
          if (mode == MODE_SELFTEST) begin
            if (e.pass) move_to(MODE_READY);
            else move_to(MODE_FAULT);
            r.request_accepted = 1'b1;
          end
        end
        KIND_HANDSHAKE, KIND_ACCEPTED: begin
          if (live) begin
            contact = 1'b1;
            last_in = now;
            if (e.kind == KIND_ACCEPTED) cnt[C_ACCEPT] += 1;
          end
        end
        KIND_REJECTED: begin
          if (e.reason >= REASON_INVALID && e.reason <= REASON_OVERSIZED)
            cnt[C_INVALID + int'(e.reason - REASON_INVALID)] += 1;
        end
        KIND_OVERFLOW: begin
          cnt[C_OVERFLOW] += 1;
          if (cnt[C_OVERFLOW] >= 32'(ovf_limit) && mode != MODE_FAULT) move_to(MODE_SAFESTOP);
        end
        KIND_STOP_REQ: begin
          cnt[C_MANUAL] += 1;
          if (mode != MODE_FAULT) move_to(MODE_SAFESTOP);
        end
        KIND_NUM_FAULT: num_fault();
        KIND_READ_CNT: if (e.sel < SEL_LIMIT) r.counter_value = cnt[e.sel];
        default: ;
      endcase
      r.state_out = mode;
      modes_seen[mode] = 1'b1;
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_outcome(logic [39:0] bus);
      result_t got;
      result_t want;
      got = bus[38:0];
      if (pending.size() == 0) begin
        report($sformatf("result %h with nothing pending", bus));
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("state_out", 32'(got.state_out), 32'(want.state_out));
      compare_field("drive_permit", 32'(got.drive_permit), 32'(want.drive_permit));
      compare_field("brake_demand", 32'(got.brake_demand), 32'(want.brake_demand));
      compare_field("neutral_hold", 32'(got.neutral_hold), 32'(want.neutral_hold));
      compare_field("request_accepted", 32'(got.request_accepted), 32'(want.request_accepted));
      compare_field("counter_value", got.counter_value, want.counter_value);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [3:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  safety_shadow shadow;
  logic [31:0]  t_now;
  int           items_sent;
  int           settings_used;
  int           cycles;
  bit           calm;
  bit           hold_req;

  navigation_safety_supervisor u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles <= LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) shadow.check_outcome(m_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic push_event(input event_t e);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= e.kind;
    s_tdata <= {3'b0, e.sel, e.reason, e.pass, e.ctl_ok, e.est_ok, e.nav, e.now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shadow.take_event(e);
    items_sent++;
  endtask

  task automatic fire(input logic [3:0] k, input logic [31:0] at,
                      input logic [2:0] nav = NAV_GNSS, input logic pass = 1'b1,
                      input logic [2:0] reason = REASON_NONE, input logic [3:0] sel = 4'd0);
    push_event('{kind: k, now: at, nav: nav, est_ok: 1'b1, ctl_ok: 1'b1, pass: pass,
                 reason: reason, sel: sel});
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] to_val, input logic [15:0] grace_val,
                              input logic [7:0] lim_val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HOST_TIMEOUT;
    cfg_wdata <= to_val;
    @(posedge clk);
    cfg_index <= CFG_UNAV_GRACE;
    cfg_wdata <= grace_val;
    @(posedge clk);
    cfg_index <= CFG_OVF_LIMIT;
    cfg_wdata <= {8'b0, lim_val};
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.set_reg(CFG_HOST_TIMEOUT, to_val);
    shadow.set_reg(CFG_UNAV_GRACE, grace_val);
    shadow.set_reg(CFG_OVF_LIMIT, {8'b0, lim_val});
    settings_used++;
  endtask

  // time steps scaled to the shorter of the two timers
  function automatic void advance_time();
    int unsigned span;
    int unsigned r;
    span = (shadow.host_to < shadow.grace) ? shadow.host_to : shadow.grace;
    r = $urandom_range(99);
    if (r < 70) t_now += $urandom_range(span / 3);
    else if (r < 97) t_now += $urandom_range(span + span / 4 + 2, span / 3);
    else t_now += $urandom();
  endfunction

  function automatic event_t random_event(input logic [3:0] k);
    event_t e;
    e.kind = k;
    e.now = ($urandom_range(99) < 3) ? $urandom() : t_now;
    e.nav = ($urandom_range(99) < 85) ? 3'($urandom_range(NAV_UNAVAIL))
                                      : 3'($urandom_range(NAV_SPARE_LAST));
    e.est_ok = $urandom_range(99) < 97;
    e.ctl_ok = $urandom_range(99) < 92;
    e.pass = $urandom_range(99) < 85;
    e.reason = 3'($urandom_range(REASON_SPARE));
    e.sel = ($urandom_range(99) < 85) ? 4'($urandom_range(NUM_CNT - 1))
                                      : 4'($urandom_range(SEL_SPARE_LAST));
    return e;
  endfunction

  function automatic logic [3:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 45) return KIND_TICK;
    if (r < 52) return KIND_HANDSHAKE;
    if (r < 60) return KIND_ACCEPTED;
    if (r < 68) return KIND_REJECTED;
    if (r < 78) return KIND_READ_CNT;
    if (r < 81) return KIND_OVERFLOW;
    if (r < 83) return KIND_STOP_REQ;
    if (r < 85) return KIND_NUM_FAULT;
    if (r < 88) return KIND_ST_START;
    if (r < 91) return KIND_ST_DONE;
    if (r < 93) return KIND_RESTART;
    if (r < 95) return 4'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
    return KIND_TICK;
  endfunction

  // mostly a clean bring-up to ready, then a random run of events
  task automatic run_session(input int length);
    event_t e;
    if ($urandom_range(99) < 88) begin
      push_event(random_event(KIND_RESTART));
      advance_time();
      push_event(random_event(KIND_ST_START));
      e = random_event(KIND_ST_DONE);
      e.pass = $urandom_range(99) < 95;
      push_event(e);
      advance_time();
      push_event(random_event(KIND_HANDSHAKE));
    end
    repeat (length) begin
      advance_time();
      push_event(random_event(pick_kind()));
    end
  endtask

  initial begin
    int start;
    shadow = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HOST_TIMEOUT;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= KIND_TICK;
    t_now = '0;
    items_sent = 0;
    settings_used = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: self-test paths, wrap of time, outage grace edge, spare codes
    fire(KIND_TICK, 32'd0);
    fire(KIND_SPARE_LAST, 32'd1);
    fire(KIND_ST_DONE, 32'd2);
    fire(KIND_ST_START, 32'd3);
    fire(KIND_ST_START, 32'd4);
    fire(KIND_ST_DONE, 32'd5, NAV_GNSS, 1'b0);
    fire(KIND_TICK, 32'd6);
    fire(KIND_STOP_REQ, 32'd7);
    fire(KIND_OVERFLOW, 32'd8);
    fire(KIND_READ_CNT, 32'd9, NAV_GNSS, 1'b1, REASON_NONE, 4'(C_MANUAL));
    fire(KIND_RESTART, 32'hFFFF_FF00);
    fire(KIND_ST_START, 32'hFFFF_FF01);
    fire(KIND_ST_DONE, 32'hFFFF_FF02);
    fire(KIND_HANDSHAKE, 32'hFFFF_FFF0);
    fire(KIND_REJECTED, 32'hFFFF_FFF1, NAV_GNSS, 1'b1, REASON_NONE);
    fire(KIND_REJECTED, 32'hFFFF_FFF2, NAV_GNSS, 1'b1, REASON_SPARE);
    fire(KIND_REJECTED, 32'hFFFF_FFF3, NAV_GNSS, 1'b1, REASON_OVERSIZED);
    fire(KIND_TICK, 32'hFFFF_FFF4, NAV_SPARE_LAST);
    fire(KIND_TICK, 32'h10, NAV_GNSS);
    fire(KIND_TICK, 32'h20, NAV_UNAVAIL);
    fire(KIND_TICK, 32'h20 + 32'd249, NAV_UNAVAIL);
    fire(KIND_TICK, 32'h20 + 32'd250, NAV_UNAVAIL);
    fire(KIND_READ_CNT, 32'h200, NAV_GNSS, 1'b1, REASON_NONE, 4'(C_TRANS));
    fire(KIND_READ_CNT, 32'h201, NAV_GNSS, 1'b1, REASON_NONE, SEL_SPARE_LAST);
    fire(KIND_ACCEPTED, 32'h202);
    fire(KIND_NUM_FAULT, 32'h203);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: program_regs(16'd1, 16'd1, 8'd1);
        1: program_regs(16'hFFFF, 16'hFFFF, 8'hFF);
        2: program_regs(16'd0, 16'd0, 8'd0);
        default: program_regs(16'($urandom_range(3000, 50)), 16'($urandom_range(1500, 20)),
                              8'($urandom_range(6, 1)));
      endcase
      if (p == 1) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        calm = (p == 3) && (items_sent - start > 100) && (items_sent - start < 300);
        run_session($urandom_range(60, 10));
      end
      calm = 1'b0;
      settle();
    end

    if (shadow.pending.size() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.pending.size()));
    $display("drove %0d events under %0d register settings, compared %0d results",
             items_sent, settings_used, shadow.checked);
    $display("safety modes reached (startup in bit 0): %b", shadow.modes_seen);
    if (shadow.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
